// File: rtl/gflt_pkg.sv
// ----------------------------------------------------------------------------
// gflt_pkg
// shared types and constants of the 5x5 gaussian line filter
// ----------------------------------------------------------------------------
`default_nettype none

package gflt_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 11'd1024;

    localparam int QUEUE_DEPTH = 4;

    // kernel, sum of weights and reciprocal for the divide by 644
    localparam int ROW_SUM_W = 17;
    localparam int SUM_W     = 18;
    localparam int PROD_W    = 33;
    localparam logic [6:0] KERN [5][5] = '{
        '{7'd5,  7'd8,  7'd10,  7'd8,  7'd5},
        '{7'd8,  7'd20, 7'd80,  7'd20, 7'd8},
        '{7'd10, 7'd80, 7'd120, 7'd80, 7'd10},
        '{7'd8,  7'd20, 7'd80,  7'd20, 7'd8},
        '{7'd5,  7'd8,  7'd10,  7'd8,  7'd5}
    };
    localparam logic [SUM_W-1:0] KSUM   = 18'd644;
    localparam logic [14:0]      RECIP  = 15'd26051;
    localparam int               RSHIFT = 24;

    typedef logic [4:0][4:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             has_filt;
        logic             has_pass;
        logic             frame_end;
    } meta_t;

    typedef struct packed {
        window_t win;
        meta_t   meta;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             filtered;
        logic             done;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/gflt_ram.sv
// ----------------------------------------------------------------------------
// gflt_ram
// simple dual port ram, one write and one registered read port, read first
// ----------------------------------------------------------------------------
`default_nettype none

module gflt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/gflt_front.sv
// ----------------------------------------------------------------------------
// gflt_front
// pixel intake: position counters, line stores, 5x5 window and classification
// ----------------------------------------------------------------------------
`default_nettype none

module gflt_front
    import gflt_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_pixel,
    output logic                      push_valid,
    output job_t                      push_job,
    input  wire logic                 q_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]    col_cnt_reg;
    logic [RW-1:0]    row_cnt_reg;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [WW:0]   c_ext;
    logic [WW:0]   w_ext;
    logic [HW:0]   r_ext;
    logic [HW:0]   h_ext;
    logic          accept;
    logic          has_filt;
    logic          has_pass;
    logic          row_end;
    logic          frame_end;

    logic             p1_valid_reg;
    logic [PIX_W-1:0] p1_pix_reg;
    logic [1:0]       p1_slot_reg;
    meta_t            p1_meta_reg;
    logic             p1_move;
    logic             p1_any;

    logic [PIX_W-1:0] rd_data [4];
    window_t          win_reg;
    window_t          win_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_SIZE_RESET;
            frame_height_reg <= FRAME_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = WW'(1);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            eff_h = HW'(1);
        end else if (int'(frame_height_reg) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(frame_height_reg);
        end
    end

    // classification of the incoming pixel
    always_comb begin
        c_ext     = (WW+1)'(col_cnt_reg);
        w_ext     = (WW+1)'(eff_w);
        r_ext     = (HW+1)'(row_cnt_reg);
        h_ext     = (HW+1)'(eff_h);
        has_filt  = (r_ext >= 4) && (c_ext >= 4) && (c_ext < w_ext) && (r_ext < h_ext);
        has_pass  = (r_ext < 2) || (c_ext < 2) || (r_ext + 2 >= h_ext) || (c_ext + 2 >= w_ext);
        row_end   = (c_ext + 1 >= w_ext);
        frame_end = row_end && (r_ext + 1 >= h_ext);
    end

    assign p1_any     = p1_meta_reg.has_filt || p1_meta_reg.has_pass;
    assign p1_move    = p1_valid_reg && (!p1_any || !q_full);
    assign s_tready   = !p1_valid_reg || p1_move;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = p1_valid_reg && p1_any && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= frame_end ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pix_reg            <= s_pixel;
            p1_slot_reg           <= row_cnt_reg[1:0];
            p1_meta_reg.pix       <= s_pixel;
            p1_meta_reg.row       <= POS_W'(row_cnt_reg);
            p1_meta_reg.col       <= POS_W'(col_cnt_reg);
            p1_meta_reg.has_filt  <= has_filt;
            p1_meta_reg.has_pass  <= has_pass;
            p1_meta_reg.frame_end <= frame_end;
        end
    end

    // four line stores, slot r&3 holds the row four above the current one
    for (genvar i = 0; i < 4; i++) begin : g_line
        gflt_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .aclk    (aclk),
            .wr_en   (accept && (row_cnt_reg[1:0] == 2'(i))),
            .wr_addr (col_cnt_reg),
            .wr_data (s_pixel),
            .rd_en   (accept),
            .rd_addr (col_cnt_reg),
            .rd_data (rd_data[i])
        );
    end

    always_comb begin
        for (int ky = 0; ky < 5; ky++) begin
            for (int kx = 0; kx < 4; kx++) begin
                win_next[ky][kx] = win_reg[ky][kx+1];
            end
        end
        for (int ky = 0; ky < 4; ky++) begin
            win_next[ky][4] = rd_data[2'(p1_slot_reg + 2'(ky))];
        end
        win_next[4][4] = p1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            win_reg <= win_next;
        end
    end

    assign push_job.win  = win_next;
    assign push_job.meta = p1_meta_reg;

endmodule

`default_nettype wire

// File: rtl/gflt_queue.sv
// ----------------------------------------------------------------------------
// gflt_queue
// short fifo of classified jobs between intake and filter datapath
// ----------------------------------------------------------------------------
`default_nettype none

module gflt_queue
    import gflt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    input  job_t      push_job,
    output logic      full,
    output logic      head_valid,
    output job_t      head_job,
    input  wire logic pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gflt_back.sv
// ----------------------------------------------------------------------------
// gflt_back
// weighted sum, divide by 644 and result sequencing with output register
// ----------------------------------------------------------------------------
`default_nettype none

module gflt_back
    import gflt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output result_t   m_result
);

    logic                 en;
    logic                 out_free;
    logic                 load;
    logic                 last;
    result_t              res;

    logic                 s1_valid_reg;
    meta_t                s1_meta_reg;
    logic [ROW_SUM_W-1:0] s1_rsum_reg [5];
    logic [ROW_SUM_W-1:0] rsum_next [5];

    logic                 s2_valid_reg;
    meta_t                s2_meta_reg;
    logic [SUM_W-1:0]     s2_total_reg;
    logic [SUM_W-1:0]     total_next;

    logic                 s3_valid_reg;
    meta_t                s3_meta_reg;
    logic [SUM_W-1:0]     s3_total_reg;
    logic [PROD_W-1:0]    s3_prod_reg;

    logic                 f_valid_reg;
    meta_t                f_meta_reg;
    logic [PIX_W-1:0]     f_q_reg;
    logic                 f_sent_reg;
    logic [PIX_W-1:0]     q0;
    logic [SUM_W-1:0]     rem;
    logic [PIX_W-1:0]     q_next;

    logic                 m_valid_reg;
    result_t              m_result_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = f_valid_reg && out_free;

    // filtered result first, pass-through second
    always_comb begin
        if (f_meta_reg.has_filt && !f_sent_reg) begin
            last         = !f_meta_reg.has_pass;
            res.pix      = f_q_reg;
            res.row      = f_meta_reg.row - POS_W'(2);
            res.col      = f_meta_reg.col - POS_W'(2);
            res.filtered = 1'b1;
            res.done     = f_meta_reg.frame_end && !f_meta_reg.has_pass;
        end else begin
            last         = 1'b1;
            res.pix      = f_meta_reg.pix;
            res.row      = f_meta_reg.row;
            res.col      = f_meta_reg.col;
            res.filtered = 1'b0;
            res.done     = f_meta_reg.frame_end;
        end
    end

    assign en  = !f_valid_reg || (load && last);
    assign pop = en && head_valid;

    always_comb begin
        logic [ROW_SUM_W-1:0] acc;
        for (int ky = 0; ky < 5; ky++) begin
            acc = '0;
            for (int kx = 0; kx < 5; kx++) begin
                acc = acc + ROW_SUM_W'(head_job.win[ky][kx]) * ROW_SUM_W'(KERN[ky][kx]);
            end
            rsum_next[ky] = acc;
        end
    end

    always_comb begin
        total_next = '0;
        for (int ky = 0; ky < 5; ky++) begin
            total_next = total_next + SUM_W'(s1_rsum_reg[ky]);
        end
    end

    // quotient estimate is exact or one low
    always_comb begin
        q0     = PIX_W'(s3_prod_reg >> RSHIFT);
        rem    = s3_total_reg - SUM_W'(q0) * KSUM;
        q_next = (rem >= KSUM) ? q0 + 1'b1 : q0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            f_valid_reg  <= 1'b0;
            f_sent_reg   <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= head_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            f_valid_reg  <= s3_valid_reg;
            f_sent_reg   <= 1'b0;
        end else if (load) begin
            f_sent_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_meta_reg  <= head_job.meta;
            s1_rsum_reg  <= rsum_next;
            s2_meta_reg  <= s1_meta_reg;
            s2_total_reg <= total_next;
            s3_meta_reg  <= s2_meta_reg;
            s3_total_reg <= s2_total_reg;
            s3_prod_reg  <= PROD_W'(s2_total_reg) * PROD_W'(RECIP);
            f_meta_reg   <= s3_meta_reg;
            f_q_reg      <= q_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

`default_nettype wire

// File: rtl/gauss_5x5_line_filter_unit.sv
// ----------------------------------------------------------------------------
// gauss_5x5_line_filter_unit
// streaming 5x5 gaussian blur of 8-bit grayscale frames in raster order
//
// pixels enter on the s_ stream, one per transaction, in raster order. every
// pixel within two of a frame edge comes back unchanged, every interior
// position comes back as the 644-weighted 5x5 sum divided by 644, tagged
// with its row and column; tuser marks a filtered pixel, tlast the final
// result of the frame. the user must write frame width and height through
// the cfg port only while the block is idle; the block itself leaves this
// unchecked. 0 acts as 1, values above the maximum act as the maximum.
// a filtered result is produced when the bottom right pixel of its window
// arrives, and is sent ahead of that pixel's own pass-through result.
// throughput is one pixel per cycle while m_tready stays high; a pixel that
// yields two results holds the output until both are sent, and the
// four-entry job queue absorbs short runs of such pixels.
// a stall on m_tready fills the datapath and queue, then drops s_tready.
// reset clears the position counters and all valid state and loads both
// frame sizes with 1024; the line stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module gauss_5x5_line_filter_unit
    import gflt_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,    // pixel_in[7:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [31:0]          m_tdata,    // pixel_out[7:0], out_row[17:8], out_col[27:18]
    output logic                      m_tuser,    // is_filtered
    output logic                      m_tlast
);

    logic    push_valid;
    job_t    push_job;
    logic    q_full;
    logic    head_valid;
    job_t    head_job;
    logic    pop;
    result_t m_result;

    gflt_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_pixel     (s_tdata),
        .push_valid  (push_valid),
        .push_job    (push_job),
        .q_full      (q_full)
    );

    gflt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    gflt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (m_result)
    );

    assign m_tdata = {4'b0000, m_result.col, m_result.row, m_result.pix};
    assign m_tuser = m_result.filtered;
    assign m_tlast = m_result.done;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking testbench of the 5x5 gaussian line filter
//
// raster pixels are sent on the s_ stream and every m_ transaction is checked
// field by field against a behavioral copy of the filter kept in this file.
// the frame size registers are written only while the block is drained.
// the run covers the reset frame size, a size change in the middle of a frame,
// sizes of zero and above the maximum, a full 1024-pixel row, and
// many small frames with random content. both stream sides insert random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import gflt_pkg::*;
;

    localparam int FRAME_MAX  = 1024;
    localparam int SETTLE_CYC = 20;
    localparam int RANDOM_PIX = 600;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = '0;    // pixel_in[7:0]
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [31:0]          m_tdata;             // pixel_out[7:0], out_row[17:8], out_col[27:18]
    logic                 m_tuser;             // is_filtered
    logic                 m_tlast;             // frame_done

    gauss_5x5_line_filter_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // filter state as seen by the stream
    logic [CFG_W-1:0] width_reg  = CFG_W'(1024);
    logic [CFG_W-1:0] height_reg = CFG_W'(1024);
    logic [7:0]       line_mem [4][FRAME_MAX];
    logic [7:0]       win_px [5][5];
    int               cur_row = 0;
    int               cur_col = 0;

    logic [7:0] pending_pix_q [$];
    result_t    expected_px_q [$];
    int         err_count = 0;

    bit pix_taken = 1'b0;
    bit res_taken = 1'b0;
    int send_gap  = 0;
    int recv_stall = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    result_t want;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic int clamp_size(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > FRAME_MAX)
            return FRAME_MAX;
        return int'(v);
    endfunction

    function automatic int tap_weight(input int ky, input int kx);
        int a;
        int b;
        a = (ky > 2) ? 4 - ky : ky;
        b = (kx > 2) ? 4 - kx : kx;
        if (a == 0)
            return (b == 0) ? 5 : (b == 1) ? 8 : 10;
        if (a == 1)
            return (b == 0) ? 8 : (b == 1) ? 20 : 80;
        return (b == 0) ? 10 : (b == 1) ? 80 : 120;
    endfunction

    // one pixel in, zero to two expected results out
    function automatic void blur_predict(input logic [7:0] pix);
        int      w;
        int      h;
        int      r;
        int      c;
        int      cm;
        int      acc;
        int      n;
        bit      row_end;
        bit      frame_end;
        logic [7:0] column [5];
        result_t outs [2];
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        r = cur_row;
        c = cur_col;
        n = 0;
        cm = (c < FRAME_MAX) ? c : FRAME_MAX - 1;
        for (int k = 0; k < 4; k++)
            column[k] = line_mem[(r + k) % 4][cm];
        column[4] = pix;
        line_mem[r % 4][cm] = pix;
        for (int ky = 0; ky < 5; ky++) begin
            for (int kx = 0; kx < 4; kx++)
                win_px[ky][kx] = win_px[ky][kx + 1];
            win_px[ky][4] = column[ky];
        end
        row_end   = (c + 1 >= w);
        frame_end = row_end && (r + 1 >= h);
        if (r >= 4 && c >= 4 && c < w && r < h) begin
            acc = 0;
            for (int ky = 0; ky < 5; ky++)
                for (int kx = 0; kx < 5; kx++)
                    acc += int'(win_px[ky][kx]) * tap_weight(ky, kx);
            outs[n].pix      = 8'(acc / 644);
            outs[n].row      = POS_W'(r - 2);
            outs[n].col      = POS_W'(c - 2);
            outs[n].filtered = 1'b1;
            outs[n].done     = 1'b0;
            n++;
        end
        if (r < 2 || c < 2 || r + 2 >= h || c + 2 >= w) begin
            outs[n].pix      = pix;
            outs[n].row      = POS_W'(r);
            outs[n].col      = POS_W'(c);
            outs[n].filtered = 1'b0;
            outs[n].done     = 1'b0;
            n++;
        end
        if (frame_end && n > 0)
            outs[n - 1].done = 1'b1;
        for (int i = 0; i < n; i++)
            expected_px_q.push_back(outs[i]);
        if (row_end) begin
            cur_col = 0;
            cur_row = frame_end ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endfunction

    task automatic check_field(input string name, input int got, input int exp_v);
        if (got != exp_v)
            report_error($sformatf("%s mismatch at row %0d col %0d: got %0d expected %0d",
                                   name, want.row, want.col, got, exp_v));
    endtask

    // monitor: sample both handshakes at the rising edge
    always @(posedge aclk) begin
        pix_taken = aresetn && s_tvalid && s_tready;
        res_taken = aresetn && m_tvalid && m_tready;
        if (pix_taken)
            blur_predict(s_tdata);
        if (res_taken) begin
            if (expected_px_q.size() == 0) begin
                report_error($sformatf("unexpected result transaction, tdata %h", m_tdata));
            end else begin
                want = expected_px_q.pop_front();
                check_field("pixel_out", int'(m_tdata[7:0]), int'(want.pix));
                check_field("out_row", int'(m_tdata[17:8]), int'(want.row));
                check_field("out_col", int'(m_tdata[27:18]), int'(want.col));
                check_field("is_filtered", int'(m_tuser), int'(want.filtered));
                check_field("frame_done", int'(m_tlast), int'(want.done));
            end
        end
    end

    // driver: pixels out of the pending queue with random gaps
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !pix_taken) begin
                s_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_pix_q.size() != 0) begin
                s_tdata  <= pending_pix_q.pop_front();
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (res_taken) begin
                if ($urandom_range(0, 39) == 0)
                    recv_burst = ~recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_pix_q.size() != 0 || s_tvalid || expected_px_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        if (idx == REG_FRAME_WIDTH)
            width_reg = val;
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pixel(input int style, input int idx);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            2: return 8'd255;
            3: return 8'(idx * 7 + $urandom_range(0, 15));
            default: return 8'd0;
        endcase
    endfunction

    task automatic queue_pixels(input int n, input int style);
        for (int i = 0; i < n; i++)
            pending_pix_q.push_back(pick_pixel(style, i));
    endtask

    task automatic frame_phase(input int wv, input int hv, input int style);
        wait_drained();
        set_reg(REG_FRAME_WIDTH, CFG_W'(wv));
        set_reg(REG_FRAME_HEIGHT, CFG_W'(hv));
        queue_pixels(clamp_size(CFG_W'(wv)) * clamp_size(CFG_W'(hv)), style);
    endtask

    initial begin
        int fed;
        int wv;
        int hv;
        int sel;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset frame size, then shrink it while inside the first row
        pending_pix_q.push_back(8'd0);
        pending_pix_q.push_back(8'd255);
        pending_pix_q.push_back(8'd1);
        pending_pix_q.push_back(8'd128);
        pending_pix_q.push_back(8'd254);
        pending_pix_q.push_back(8'd127);
        frame_phase(1, 1, 2);

        // smallest frame with an interior pixel, brightest content
        frame_phase(5, 5, 2);
        // zero sizes act as one
        frame_phase(0, 0, 1);
        frame_phase(0, 0, 4);
        // sizes above the maximum act as the maximum
        frame_phase(2047, 1, 0);

        fed = 0;
        while (fed < RANDOM_PIX) begin
            sel = $urandom_range(0, 9);
            wv = (sel < 7) ? $urandom_range(5, 12) :
                 (sel < 9) ? $urandom_range(13, 40) : $urandom_range(0, 4);
            sel = $urandom_range(0, 19);
            hv = (sel < 15) ? $urandom_range(5, 10) :
                 (sel < 18) ? $urandom_range(0, 4) : $urandom_range(11, 20);
            sel = $urandom_range(0, 9);
            frame_phase(wv, hv, (sel < 5) ? 0 : sel - 5);
            fed += clamp_size(CFG_W'(wv)) * clamp_size(CFG_W'(hv));
        end

        wait_drained();
        if (expected_px_q.size() != 0)
            report_error($sformatf("%0d expected results never arrived", expected_px_q.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
